@@ rtl/core/stb_pkg.sv @@
// Shared constants for the surface tangent basis block.
package stb_pkg;

    localparam int COMPONENT_WIDTH = 16;
    localparam int FRACTION_BITS   = 14;

    // Normalized magnitudes never exceed 2^31, so they fit in 32 bits.
    localparam int NORM_WIDTH = 32;
    // A sum of three squares of normalized magnitudes stays below 2^64.
    localparam int SUM_WIDTH  = 64;
    // Largest magnitude allowed before the direction is scaled down.
    localparam logic [63:0] MAG_LIMIT = 64'd1 << 31;

    localparam logic [1:0] KIND_OTHER = 2'd3;

endpackage

@@ rtl/core/stb_cell.sv @@
// One digit cell of the unit-length recurrence: decides one result bit per cycle while enabled.
module stb_cell #(
    parameter int SW = stb_pkg::SUM_WIDTH,
    parameter int FB = stb_pkg::FRACTION_BITS
) (
    input  logic               clk,
    input  logic               en,
    input  logic [SW+FB+4:0]   p_in,
    input  logic [SW+FB+1:0]   q_in,
    input  logic [SW-1:0]      s_in,
    input  logic [FB+1:0]      t_in,
    input  logic               sign_in,
    input  logic               zero_in,
    output logic [SW+FB+4:0]   p_out,
    output logic [SW+FB+1:0]   q_out,
    output logic [SW-1:0]      s_out,
    output logic [FB+1:0]      t_out,
    output logic               sign_out,
    output logic               zero_out
);

    localparam int TW = FB + 2;
    localparam int QW = SW + FB + 2;
    localparam int PW = SW + FB + 5;

    logic [PW-1:0] trial;
    logic [PW-1:0] p_rem;
    logic          take;

    logic [PW-1:0] p_reg;
    logic [QW-1:0] q_reg;
    logic [SW-1:0] s_reg;
    logic [TW-1:0] t_reg;
    logic          sign_reg;
    logic          zero_reg;

    // The remainder is kept scaled by 4 per digit; q tracks s times the partial result.
    assign trial = PW'({q_in, 2'b00}) + PW'(s_in);
    assign take  = (p_in >= trial);
    assign p_rem = take ? (p_in - trial) : p_in;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg    <= {p_rem[PW-3:0], 2'b00};
            q_reg    <= {q_in[QW-2:0], 1'b0} + (take ? QW'(s_in) : QW'(0));
            s_reg    <= s_in;
            t_reg    <= {t_in[TW-2:0], take};
            sign_reg <= sign_in;
            zero_reg <= zero_in;
        end
    end

    assign p_out    = p_reg;
    assign q_out    = q_reg;
    assign s_out    = s_reg;
    assign t_out    = t_reg;
    assign sign_out = sign_reg;
    assign zero_out = zero_reg;

endmodule

@@ rtl/core/stb_row.sv @@
// Row of digit cells that turns one squared magnitude and a squared length into a scaled ratio.
module stb_row #(
    parameter int SW = stb_pkg::SUM_WIDTH,
    parameter int FB = stb_pkg::FRACTION_BITS
) (
    input  logic          clk,
    input  logic [FB+1:0] en,
    input  logic [SW-1:0] p_in,
    input  logic [SW-1:0] s_in,
    input  logic          sign_in,
    input  logic          zero_in,
    output logic [FB+1:0] t_out,
    output logic          sign_out,
    output logic          zero_out
);

    localparam int TW = FB + 2;
    localparam int QW = SW + FB + 2;
    localparam int PW = SW + FB + 5;

    logic [PW-1:0] pc  [TW+1];
    logic [QW-1:0] qc  [TW+1];
    logic [SW-1:0] sc  [TW+1];
    logic [TW-1:0] tc  [TW+1];
    logic          sgc [TW+1];
    logic          zc  [TW+1];

    assign pc[0]  = PW'(p_in);
    assign qc[0]  = '0;
    assign sc[0]  = s_in;
    assign tc[0]  = '0;
    assign sgc[0] = sign_in;
    assign zc[0]  = zero_in;

    for (genvar c = 0; c < TW; c++)
    begin : g_cell
        stb_cell #(
            .SW (SW),
            .FB (FB)
        ) u_cell (
            .clk      (clk),
            .en       (en[c]),
            .p_in     (pc[c]),
            .q_in     (qc[c]),
            .s_in     (sc[c]),
            .t_in     (tc[c]),
            .sign_in  (sgc[c]),
            .zero_in  (zc[c]),
            .p_out    (pc[c+1]),
            .q_out    (qc[c+1]),
            .s_out    (sc[c+1]),
            .t_out    (tc[c+1]),
            .sign_out (sgc[c+1]),
            .zero_out (zc[c+1])
        );
    end

    assign t_out    = tc[TW];
    assign sign_out = sgc[TW];
    assign zero_out = zc[TW];

endmodule

@@ rtl/core/surface_tangent_basis.sv @@
// Top level of the surface tangent basis block: front stages, cell rows and result register.
//
// Takes one request per cycle unless stalled and returns one result per request, in order.
// Seven front stages form the cross product, scale it to at most 2^31 and square it, then
// top y, top z and the three right components each pass through a row of
// FRACTION_BITS + 2 digit cells that each settle one bit of the ratio, and a final stage
// rounds, saturates and registers the result. Each stage holds its request while the next
// cannot take one, so empty stages keep taking requests while a result waits on the output.
// The top vector follows from which normal components are zero; other object kinds return
// all zeros with basis_valid clear.
module surface_tangent_basis #(
    parameter int  COMPONENT_WIDTH = stb_pkg::COMPONENT_WIDTH,
    parameter int  FRACTION_BITS   = stb_pkg::FRACTION_BITS,
    localparam int IN_DW           = ((3 * COMPONENT_WIDTH + 7) / 8) * 8,
    localparam int OUT_DW          = ((6 * COMPONENT_WIDTH + 7) / 8) * 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_DW-1:0]  s_tdata,   // normal_x, normal_y, normal_z
    input  logic [1:0]        s_tuser,   // object_kind
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_DW-1:0] m_tdata,   // top_x, top_y, top_z, right_x, right_y, right_z
    output logic [1:0]        m_tuser    // basis_valid, degenerate
);

    localparam int CW   = COMPONENT_WIDTH;
    localparam int FB   = FRACTION_BITS;
    localparam int RW   = 2 * CW;
    localparam int NW   = stb_pkg::NORM_WIDTH;
    localparam int SW   = stb_pkg::SUM_WIDTH;
    localparam int TW   = FB + 2;
    localparam int SHW  = $clog2(RW + 1);
    localparam int CST  = 7;
    localparam int NST  = TW + 8;
    localparam int OST  = NST - 1;
    localparam int NLN  = 5;

    localparam logic [63:0]   UNIT64   = 64'd1 << FB;
    localparam logic [63:0]   POS_LIM  = (64'd1 << (CW - 1)) - 64'd1;
    localparam logic [63:0]   NEG_LIM  = 64'd1 << (CW - 1);
    localparam logic [CW-1:0] POS_MAX  = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] NEG_MIN  = {1'b1, {(CW-1){1'b0}}};
    localparam logic [CW-1:0] ONE_CODE = (FB < CW - 1) ? CW'(UNIT64) : POS_MAX;
    localparam logic [CW-1:0] MONE_CODE = (FB < CW) ? CW'(64'd0 - UNIT64) : NEG_MIN;

    typedef struct packed {
        logic          basis;
        logic          general;
        logic          degenerate;
        logic [CW-1:0] tx;
        logic [CW-1:0] ty;
        logic [CW-1:0] tz;
    } side_t;

    typedef struct packed {
        logic [RW-1:0] s;
        logic [RW-1:0] py;
        logic [RW-1:0] pz;
        logic          sy;
        logic          sz;
    } tlane_t;

    function automatic logic [SHW-1:0] shift_need(input logic [RW-1:0] m);
        logic [63:0] w;
        logic [6:0]  bl;
        logic [6:0]  e;
        logic [63:0] hi;
        begin
            w  = 64'(m);
            bl = '0;
            for (int b = 0; b < 64; b++)
            begin
                if (w[b])
                begin
                    bl = 7'(b + 1);
                end
            end
            e  = (bl > 7'd32) ? (bl - 7'd32) : 7'd0;
            hi = w >> e;
            if (w > stb_pkg::MAG_LIMIT)
            begin
                shift_need = SHW'(e + ((hi != stb_pkg::MAG_LIMIT) ? 7'd1 : 7'd0));
            end
            else
            begin
                shift_need = '0;
            end
        end
    endfunction

    function automatic logic [CW-1:0] encode(input logic neg, input logic [TW-1:0] t);
        logic [TW-1:0] k;
        logic [63:0]   k64;
        begin
            k   = (t + TW'(1)) >> 1;
            k64 = 64'(k);
            if (!neg)
            begin
                encode = (k64 > POS_LIM) ? POS_MAX : CW'(k64);
            end
            else
            begin
                encode = (k64 > NEG_LIM) ? NEG_MIN : CW'(64'd0 - k64);
            end
        end
    endfunction

    // Stage handshake: a stage takes new data when it is empty or its successor moves.
    logic [NST-1:0] v_reg;
    logic [NST-1:0] rdy;

    assign rdy[OST] = !v_reg[OST] || m_tready;
    for (genvar g = 0; g < OST; g++)
    begin : g_rdy
        assign rdy[g] = !v_reg[g] || rdy[g+1];
    end

    assign s_tready = rdy[0];
    assign m_tvalid = v_reg[OST];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NST; i++)
            begin
                if (rdy[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // Stage 0: capture as sign and magnitude.
    logic [2:0][CW-1:0] raw;
    logic [2:0][CW-1:0] mag0_next;
    logic [1:0]         kind0_reg;
    logic [2:0]         sgn0_reg;
    logic [2:0][CW-1:0] mag0_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            raw[i]       = s_tdata[i*CW +: CW];
            mag0_next[i] = raw[i][CW-1] ? (CW'(0) - raw[i]) : raw[i];
        end
    end

    // Stage 1: products and case decode.
    logic [RW-1:0]      ny2_1_reg;
    logic [RW-1:0]      nz2_1_reg;
    logic [RW-1:0]      nxy_1_reg;
    logic [RW-1:0]      nxz_1_reg;
    logic [2:0]         sgn1_reg;
    logic [2:0][CW-1:0] mag1_reg;
    logic               zx1_reg;
    logic               zy1_reg;
    logic               zz1_reg;
    side_t              side1_next;
    side_t              side1_reg;
    logic               zx;
    logic               zy;
    logic               zz;

    assign zx = (mag0_reg[0] == '0);
    assign zy = (mag0_reg[1] == '0);
    assign zz = (mag0_reg[2] == '0);

    always_comb
    begin
        side1_next.basis      = (kind0_reg != stb_pkg::KIND_OTHER);
        side1_next.general    = !zx && !zy && !zz;
        side1_next.degenerate = zx && zy && zz;
        side1_next.tx         = zx ? ONE_CODE : '0;
        side1_next.ty         = (!zx && zy) ? ONE_CODE : '0;
        side1_next.tz         = (!zx && !zy && zz) ? MONE_CODE : '0;
    end

    // Stage 2: cross product direction and top lane inputs.
    logic [2:0][RW-1:0] rv2_next;
    logic [2:0]         rs2_next;
    tlane_t             tl2_next;
    logic [2:0][RW-1:0] rv2_reg;
    logic [2:0]         rs2_reg;
    tlane_t             tl2_reg;
    side_t              side2_reg;

    always_comb
    begin
        tl2_next.s  = ny2_1_reg + nz2_1_reg;
        tl2_next.py = nz2_1_reg;
        tl2_next.pz = ny2_1_reg;
        tl2_next.sy = sgn1_reg[2] ^ sgn1_reg[1];
        tl2_next.sz = 1'b1;
        if (zx1_reg)
        begin
            rv2_next = {RW'(mag1_reg[1]), RW'(mag1_reg[2]), RW'(0)};
            rs2_next = {sgn1_reg[1], !sgn1_reg[2], 1'b0};
        end
        else if (zy1_reg)
        begin
            rv2_next = {RW'(mag1_reg[0]), RW'(0), RW'(mag1_reg[2])};
            rs2_next = {!sgn1_reg[0], 1'b0, sgn1_reg[2]};
        end
        else if (zz1_reg)
        begin
            rv2_next = {RW'(0), RW'(mag1_reg[0]), RW'(mag1_reg[1])};
            rs2_next = {1'b0, !sgn1_reg[0], sgn1_reg[1]};
        end
        else
        begin
            rv2_next = {nxz_1_reg, nxy_1_reg, ny2_1_reg + nz2_1_reg};
            rs2_next = {!(sgn1_reg[0] ^ sgn1_reg[1] ^ sgn1_reg[2]), !sgn1_reg[0], sgn1_reg[1]};
        end
    end

    // Stage 3: shift each component needs to stay within 2^31.
    logic [2:0][SHW-1:0] k3_reg;
    logic [2:0][RW-1:0]  rv3_reg;
    logic [2:0]          rs3_reg;
    tlane_t              tl3_reg;
    side_t               side3_reg;

    // Stage 4: common shift applied.
    logic [SHW-1:0]      kmax;
    logic [2:0][NW-1:0]  nm4_reg;
    logic [2:0]          rs4_reg;
    tlane_t              tl4_reg;
    side_t               side4_reg;

    always_comb
    begin
        kmax = k3_reg[0];
        if (k3_reg[1] > kmax)
        begin
            kmax = k3_reg[1];
        end
        if (k3_reg[2] > kmax)
        begin
            kmax = k3_reg[2];
        end
    end

    // Stage 5: squares; stage 6: squared length.
    logic [2:0][SW-1:0] sq5_reg;
    logic [2:0]         rs5_reg;
    tlane_t             tl5_reg;
    side_t              side5_reg;
    logic [2:0][SW-1:0] sq6_reg;
    logic [SW-1:0]      sr6_reg;
    logic [2:0]         rs6_reg;
    tlane_t             tl6_reg;
    side_t              side6_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            kind0_reg <= s_tuser;
            for (int i = 0; i < 3; i++)
            begin
                sgn0_reg[i] <= raw[i][CW-1];
            end
            mag0_reg <= mag0_next;
        end
        if (rdy[1])
        begin
            ny2_1_reg <= RW'(mag0_reg[1]) * RW'(mag0_reg[1]);
            nz2_1_reg <= RW'(mag0_reg[2]) * RW'(mag0_reg[2]);
            nxy_1_reg <= RW'(mag0_reg[0]) * RW'(mag0_reg[1]);
            nxz_1_reg <= RW'(mag0_reg[0]) * RW'(mag0_reg[2]);
            sgn1_reg  <= sgn0_reg;
            mag1_reg  <= mag0_reg;
            zx1_reg   <= zx;
            zy1_reg   <= zy;
            zz1_reg   <= zz;
            side1_reg <= side1_next;
        end
        if (rdy[2])
        begin
            rv2_reg   <= rv2_next;
            rs2_reg   <= rs2_next;
            tl2_reg   <= tl2_next;
            side2_reg <= side1_reg;
        end
        if (rdy[3])
        begin
            for (int i = 0; i < 3; i++)
            begin
                k3_reg[i] <= shift_need(rv2_reg[i]);
            end
            rv3_reg   <= rv2_reg;
            rs3_reg   <= rs2_reg;
            tl3_reg   <= tl2_reg;
            side3_reg <= side2_reg;
        end
        if (rdy[4])
        begin
            for (int i = 0; i < 3; i++)
            begin
                nm4_reg[i] <= NW'(64'(rv3_reg[i]) >> kmax);
            end
            rs4_reg   <= rs3_reg;
            tl4_reg   <= tl3_reg;
            side4_reg <= side3_reg;
        end
        if (rdy[5])
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq5_reg[i] <= SW'(nm4_reg[i]) * SW'(nm4_reg[i]);
            end
            rs5_reg   <= rs4_reg;
            tl5_reg   <= tl4_reg;
            side5_reg <= side4_reg;
        end
        if (rdy[6])
        begin
            sq6_reg   <= sq5_reg;
            sr6_reg   <= sq5_reg[0] + sq5_reg[1] + sq5_reg[2];
            rs6_reg   <= rs5_reg;
            tl6_reg   <= tl5_reg;
            side6_reg <= side5_reg;
        end
    end

    // Cell rows: lanes are top y, top z, right x, right y, right z.
    logic [SW-1:0] lane_p  [NLN];
    logic [SW-1:0] lane_s  [NLN];
    logic          lane_sg [NLN];
    logic          lane_z  [NLN];
    logic [TW-1:0] lane_t  [NLN];
    logic          lane_so [NLN];
    logic          lane_zo [NLN];

    always_comb
    begin
        lane_p[0]  = SW'(tl6_reg.py);
        lane_p[1]  = SW'(tl6_reg.pz);
        lane_s[0]  = SW'(tl6_reg.s);
        lane_s[1]  = SW'(tl6_reg.s);
        lane_sg[0] = tl6_reg.sy;
        lane_sg[1] = tl6_reg.sz;
        lane_z[0]  = (tl6_reg.s == '0);
        lane_z[1]  = (tl6_reg.s == '0);
        for (int i = 0; i < 3; i++)
        begin
            lane_p[i+2]  = sq6_reg[i];
            lane_s[i+2]  = sr6_reg;
            lane_sg[i+2] = rs6_reg[i];
            lane_z[i+2]  = (sr6_reg == '0);
        end
    end

    for (genvar l = 0; l < NLN; l++)
    begin : g_lane
        stb_row #(
            .SW (SW),
            .FB (FB)
        ) u_row (
            .clk      (clk),
            .en       (rdy[CST +: TW]),
            .p_in     (lane_p[l]),
            .s_in     (lane_s[l]),
            .sign_in  (lane_sg[l]),
            .zero_in  (lane_z[l]),
            .t_out    (lane_t[l]),
            .sign_out (lane_so[l]),
            .zero_out (lane_zo[l])
        );
    end

    side_t sbc_reg [TW];

    always_ff @(posedge clk)
    begin
        if (rdy[CST])
        begin
            sbc_reg[0] <= side6_reg;
        end
        for (int c = 1; c < TW; c++)
        begin
            if (rdy[CST+c])
            begin
                sbc_reg[c] <= sbc_reg[c-1];
            end
        end
    end

    // Result stage: round, saturate and select.
    logic [CW-1:0]        code [NLN];
    side_t                sb;
    logic [5:0][CW-1:0]   res_next;
    logic [5:0][CW-1:0]   res_reg;
    logic [1:0]           flag_next;
    logic [1:0]           flag_reg;

    assign sb = sbc_reg[TW-1];

    always_comb
    begin
        for (int l = 0; l < NLN; l++)
        begin
            code[l] = lane_zo[l] ? '0 : encode(lane_so[l], lane_t[l]);
        end
        if (sb.general)
        begin
            res_next[0] = '0;
            res_next[1] = code[0];
            res_next[2] = code[1];
        end
        else
        begin
            res_next[0] = sb.tx;
            res_next[1] = sb.ty;
            res_next[2] = sb.tz;
        end
        res_next[3] = code[2];
        res_next[4] = code[3];
        res_next[5] = code[4];
        flag_next   = {sb.degenerate, 1'b1};
        if (!sb.basis)
        begin
            res_next  = '0;
            flag_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[OST])
        begin
            res_reg  <= res_next;
            flag_reg <= flag_next;
        end
    end

    assign m_tdata = OUT_DW'(res_reg);
    assign m_tuser = flag_reg;

    // An empty result register means every stage can take a request.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !v_reg[OST] |-> s_tready)
        else $error("input stalled while the result register is empty");

    a_other_kind_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0 && !m_tuser[1]))
        else $error("result without a basis carries data");

    a_degenerate_right_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> (m_tdata[6*CW-1:3*CW] == '0 && m_tdata[CW-1:0] == ONE_CODE))
        else $error("degenerate result with nonzero right vector or wrong top");

    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> v_reg[0])
        else $error("accepted request did not enter the first stage");

endmodule

@@ dv/surface_tangent_basis_test.sv @@
// Testbench for surface_tangent_basis: directed and random normals checked against a predictor.
`timescale 1ns / 1ps

module surface_tangent_basis_test;

    localparam int CW = stb_pkg::COMPONENT_WIDTH;
    localparam int IN_DW = ((3 * CW + 7) / 8) * 8;
    localparam int OUT_DW = ((6 * CW + 7) / 8) * 8;
    localparam logic [1:0] KIND_PLANE = 2'd0;
    localparam logic [1:0] KIND_CYLINDER = 2'd1;
    localparam logic [1:0] KIND_CONE = 2'd2;
    localparam logic signed [CW-1:0] COMP_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] COMP_MIN = {1'b1, {(CW-1){1'b0}}};

    typedef struct packed {
        logic            neg;
        logic [63:0]     mag;
    } dir_comp_t;

    typedef struct packed {
        logic            basis_valid;
        logic            degenerate;
        logic [CW-1:0]   top_x;
        logic [CW-1:0]   top_y;
        logic [CW-1:0]   top_z;
        logic [CW-1:0]   right_x;
        logic [CW-1:0]   right_y;
        logic [CW-1:0]   right_z;
    } basis_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_DW-1:0]  s_tdata;
    logic [1:0]        s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_DW-1:0] m_tdata;
    logic [1:0]        m_tuser;

    basis_t expected_basis_q[$];
    int     error_count = 0;
    int     hold_off_cycles = 0;
    bit     idle_on = 1'b1;

    surface_tangent_basis DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("FAIL surface_tangent_basis");
        $finish;
    end

    // Exact rounded check: is round(mag * 2^FB / sqrt(s)) at least k?
    function automatic bit ratio_reaches(logic [63:0] mag, logic [63:0] s, logic [63:0] k);
        logic [127:0] l;
        logic [127:0] r;
        begin
            l = {64'd0, mag} << (stb_pkg::FRACTION_BITS + 1);
            r = 128'(2 * k - 1);
            return (l * l) >= (r * r * {64'd0, s});
        end
    endfunction

    function automatic logic [CW-1:0] encode_code(logic neg, logic [63:0] k);
        logic [63:0] lim;
        begin
            lim = 64'd1 << (CW - 1);
            if (!neg)
                return (k > lim - 1) ? CW'(lim - 1) : CW'(k);
            if (k > lim)
                k = lim;
            return CW'(64'd0 - k);
        end
    endfunction

    // Returns {z, y, x} codes of the unit vector along (a, b, c).
    function automatic logic [3*CW-1:0] unit_direction(dir_comp_t a, dir_comp_t b, dir_comp_t c);
        dir_comp_t   v[3];
        logic [63:0] s;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [3*CW-1:0] codes;
        begin
            v[0] = a;
            v[1] = b;
            v[2] = c;
            codes = '0;
            while (v[0].mag > stb_pkg::MAG_LIMIT || v[1].mag > stb_pkg::MAG_LIMIT
                   || v[2].mag > stb_pkg::MAG_LIMIT)
                for (int i = 0; i < 3; i++)
                    v[i].mag = v[i].mag >> 1;
            s = 0;
            for (int i = 0; i < 3; i++)
                s = s + v[i].mag * v[i].mag;
            for (int i = 0; i < 3; i++)
            begin
                if (s != 0 && v[i].mag != 0)
                begin
                    lo = 0;
                    hi = 64'd1 << stb_pkg::FRACTION_BITS;
                    while (lo < hi)
                    begin
                        mid = lo + (hi - lo + 1) / 2;
                        if (ratio_reaches(v[i].mag, s, mid))
                            lo = mid;
                        else
                            hi = mid - 1;
                    end
                    codes[i*CW +: CW] = encode_code(v[i].neg, lo);
                end
            end
            return codes;
        end
    endfunction

    function automatic dir_comp_t signed_to_dir(logic signed [CW-1:0] x);
        dir_comp_t d;
        begin
            d.neg = x[CW-1];
            d.mag = x[CW-1] ? 64'(-longint'(x)) : 64'(longint'(x));
            return d;
        end
    endfunction

    function automatic basis_t predict_basis(logic [1:0] kind, logic signed [CW-1:0] x,
                                             logic signed [CW-1:0] y, logic signed [CW-1:0] z);
        basis_t    b;
        dir_comp_t nx;
        dir_comp_t ny;
        dir_comp_t nz;
        dir_comp_t r0;
        dir_comp_t r1;
        dir_comp_t r2;
        logic [3*CW-1:0] codes;
        begin
            b = '0;
            if (kind == stb_pkg::KIND_OTHER)
                return b;
            b.basis_valid = 1'b1;
            nx = signed_to_dir(x);
            ny = signed_to_dir(y);
            nz = signed_to_dir(z);
            if (nx.mag == 0)
            begin
                b.top_x = encode_code(1'b0, 64'd1 << stb_pkg::FRACTION_BITS);
                if (ny.mag == 0 && nz.mag == 0)
                begin
                    b.degenerate = 1'b1;
                    return b;
                end
                r0 = '{1'b0, 64'd0};
                r1 = '{~nz.neg, nz.mag};
                r2 = ny;
            end
            else if (ny.mag == 0)
            begin
                b.top_y = encode_code(1'b0, 64'd1 << stb_pkg::FRACTION_BITS);
                r0 = nz;
                r1 = '{1'b0, 64'd0};
                r2 = '{~nx.neg, nx.mag};
            end
            else if (nz.mag == 0)
            begin
                b.top_z = encode_code(1'b1, 64'd1 << stb_pkg::FRACTION_BITS);
                r0 = ny;
                r1 = '{~nx.neg, nx.mag};
                r2 = '{1'b0, 64'd0};
            end
            else
            begin
                // Top points along (0, nz/ny, -1); right uses the exact cross product.
                codes = unit_direction('{1'b0, 64'd0}, '{nz.neg ^ ny.neg, nz.mag},
                                       '{1'b1, ny.mag});
                {b.top_z, b.top_y, b.top_x} = codes;
                r0 = '{ny.neg, ny.mag * ny.mag + nz.mag * nz.mag};
                r1 = '{~nx.neg, nx.mag * ny.mag};
                r2 = '{~(nx.neg ^ ny.neg ^ nz.neg), nx.mag * nz.mag};
            end
            codes = unit_direction(r0, r1, r2);
            {b.right_z, b.right_y, b.right_x} = codes;
            return b;
        end
    endfunction

    task automatic report_mismatch(string field, logic [CW-1:0] got, logic [CW-1:0] want);
        begin
            $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, field, got, want);
            error_count++;
        end
    endtask

    function automatic int gap_length();
        int r;
        begin
            r = $urandom_range(0, 99);
            if (!idle_on || r < 55)
                return 0;
            if (r < 92)
                return $urandom_range(1, 3);
            return $urandom_range(10, 40);
        end
    endfunction

    task automatic check_result();
        basis_t want;
        basis_t got;
        begin
            got.basis_valid = m_tuser[0];
            got.degenerate = m_tuser[1];
            {got.right_z, got.right_y, got.right_x, got.top_z, got.top_y, got.top_x} =
                m_tdata[6*CW-1:0];
            if (expected_basis_q.size() == 0)
            begin
                $display("[%0t] result with no request outstanding", $realtime);
                error_count++;
            end
            else
            begin
                want = expected_basis_q.pop_front();
                if (got.basis_valid != want.basis_valid)
                    report_mismatch("basis_valid", CW'(got.basis_valid), CW'(want.basis_valid));
                if (got.degenerate != want.degenerate)
                    report_mismatch("degenerate", CW'(got.degenerate), CW'(want.degenerate));
                if (got.top_x != want.top_x)
                    report_mismatch("top_x", got.top_x, want.top_x);
                if (got.top_y != want.top_y)
                    report_mismatch("top_y", got.top_y, want.top_y);
                if (got.top_z != want.top_z)
                    report_mismatch("top_z", got.top_z, want.top_z);
                if (got.right_x != want.right_x)
                    report_mismatch("right_x", got.right_x, want.right_x);
                if (got.right_y != want.right_y)
                    report_mismatch("right_y", got.right_y, want.right_y);
                if (got.right_z != want.right_z)
                    report_mismatch("right_z", got.right_z, want.right_z);
            end
        end
    endtask

    // Result side: checks every accepted result and drives m_tready with random stalls.
    initial
    begin
        int stall_left;
        stall_left = 0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                check_result();
            if (hold_off_cycles > 0)
            begin
                hold_off_cycles--;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 5) == 0)
                    stall_left = gap_length();
            end
        end
    end

    task automatic send_request(logic [1:0] kind, logic signed [CW-1:0] x,
                                logic signed [CW-1:0] y, logic signed [CW-1:0] z,
                                bit no_gap = 1'b0);
        int gap;
        begin
            s_tvalid <= 1'b1;
            s_tuser <= kind;
            s_tdata <= IN_DW'({z, y, x});
            do
                @(posedge clk);
            while (!s_tready);
            expected_basis_q.push_back(predict_basis(kind, x, y, z));
            gap = no_gap ? 0 : gap_length();
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    function automatic logic signed [CW-1:0] random_component();
        int r;
        begin
            r = $urandom_range(0, 99);
            if (r < 15)
                return '0;
            if (r < 20)
                return COMP_MAX;
            if (r < 25)
                return COMP_MIN;
            if (r < 35)
                return CW'($urandom_range(0, 7)) - CW'(4);
            return CW'($urandom());
        end
    endfunction

    task automatic test_kinds();
        begin
            send_request(KIND_PLANE, 16'sd16384, 16'sd0, 16'sd0);
            send_request(KIND_CYLINDER, 16'sd0, 16'sd16384, 16'sd0);
            send_request(KIND_CONE, 16'sd0, 16'sd0, -16'sd16384);
            send_request(stb_pkg::KIND_OTHER, 16'sd1234, -16'sd77, 16'sd999);
            send_request(stb_pkg::KIND_OTHER, COMP_MIN, COMP_MAX, COMP_MIN);
        end
    endtask

    task automatic test_special_normals();
        begin
            // Zero normal gives a degenerate basis.
            send_request(KIND_PLANE, 16'sd0, 16'sd0, 16'sd0);
            send_request(KIND_CONE, 16'sd0, 16'sd0, 16'sd0);
            // Each branch of the top selection.
            send_request(KIND_PLANE, 16'sd0, -16'sd300, 16'sd5000);
            send_request(KIND_CYLINDER, 16'sd9000, 16'sd0, -16'sd2);
            send_request(KIND_CONE, -16'sd1, 16'sd7, 16'sd0);
            send_request(KIND_PLANE, 16'sd3, -16'sd5, 16'sd11);
        end
    endtask

    task automatic test_extremes();
        begin
            send_request(KIND_PLANE, COMP_MAX, COMP_MAX, COMP_MAX);
            send_request(KIND_CYLINDER, COMP_MIN, COMP_MIN, COMP_MIN);
            send_request(KIND_CONE, COMP_MIN, COMP_MAX, COMP_MIN);
            send_request(KIND_PLANE, COMP_MAX, COMP_MIN, COMP_MAX);
            send_request(KIND_PLANE, 16'sd1, COMP_MIN, 16'sd1);
            send_request(KIND_CYLINDER, -16'sd1, -16'sd1, COMP_MAX);
            send_request(KIND_CONE, 16'sd0, COMP_MIN, 16'sd0);
            send_request(KIND_PLANE, COMP_MIN, 16'sd0, 16'sd0);
            send_request(KIND_PLANE, 16'sd0, 16'sd0, COMP_MIN);
        end
    endtask

    task automatic test_random(int count);
        logic [1:0] kind;
        begin
            for (int i = 0; i < count; i++)
            begin
                kind = ($urandom_range(0, 9) == 0) ? stb_pkg::KIND_OTHER
                                                   : 2'($urandom_range(0, 2));
                idle_on = ((i / 150) % 3) != 2;
                send_request(kind, random_component(), random_component(), random_component());
            end
            idle_on = 1'b1;
        end
    endtask

    // The receiver holds off long enough for the pipeline to fill and stall its input.
    task automatic test_output_hold_off();
        begin
            hold_off_cycles = 200;
            for (int i = 0; i < 60; i++)
                send_request(2'($urandom_range(0, 3)), random_component(), random_component(),
                             random_component(), 1'b1);
        end
    endtask

    task automatic test_drain_pause();
        begin
            s_tvalid <= 1'b0;
            wait (expected_basis_q.size() == 0);
            @(posedge clk);
            test_random(30);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_kinds();
        test_special_normals();
        test_extremes();
        test_random(500);
        test_output_hold_off();
        test_drain_pause();
        test_random(640);
        s_tvalid <= 1'b0;
        wait (expected_basis_q.size() == 0);
        repeat (40) @(posedge clk);
        if (error_count == 0)
            $display("PASS surface_tangent_basis");
        else
            $display("FAIL surface_tangent_basis");
        $finish;
    end

endmodule
